// ----- hw/rtl/dsr_pkg.sv -----
// Shared types, constants and the microcode table of the distance speed ramp.
package dsr_pkg;

  localparam logic [14:0] FULL_SPEED_Q8 = 15'd32512;
  localparam logic [6:0]  MAX_WHOLE     = 7'd127;
  localparam int          QUOT_W        = 39;
  localparam int          DIV_STEPS     = 39;
  localparam int          DIV_CNT_W     = $clog2(DIV_STEPS + 1);

  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_STEP  = 2'd1;
  localparam logic [1:0] MODE_LIMIT = 2'd2;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_POS  = 2'd1;
  localparam logic [1:0] DIR_NEG  = 2'd2;

  localparam logic CFG_MIN_SPEED = 1'b0;
  localparam logic CFG_RAMP_DIST = 1'b1;

  localparam logic [3:0] OP_FETCH = 4'd0;
  localparam logic [3:0] OP_START = 4'd1;
  localparam logic [3:0] OP_NOP   = 4'd2;
  localparam logic [3:0] OP_SLOPE = 4'd3;
  localparam logic [3:0] OP_ERR   = 4'd4;
  localparam logic [3:0] OP_MAG   = 4'd5;
  localparam logic [3:0] OP_MUL   = 4'd6;
  localparam logic [3:0] OP_CLAMP = 4'd7;
  localparam logic [3:0] OP_LIMIT = 4'd8;
  localparam logic [3:0] OP_EMIT  = 4'd9;

  localparam logic [2:0] CND_NEXT  = 3'd0;
  localparam logic [2:0] CND_JUMP  = 3'd1;
  localparam logic [2:0] CND_FETCH = 3'd2;
  localparam logic [2:0] CND_SKIP  = 3'd3;
  localparam logic [2:0] CND_DIV   = 3'd4;
  localparam logic [2:0] CND_OUT   = 3'd5;

  localparam logic [3:0] PC_FETCH = 4'd0;
  localparam logic [3:0] PC_START = 4'd1;
  localparam logic [3:0] PC_DIV   = 4'd2;
  localparam logic [3:0] PC_SLOPE = 4'd3;
  localparam logic [3:0] PC_ERR   = 4'd4;
  localparam logic [3:0] PC_MAG   = 4'd5;
  localparam logic [3:0] PC_MUL   = 4'd6;
  localparam logic [3:0] PC_CLAMP = 4'd7;
  localparam logic [3:0] PC_LIMIT = 4'd8;
  localparam logic [3:0] PC_EMIT  = 4'd9;

  typedef struct packed {
    logic [3:0] op;
    logic [2:0] cond;
    logic [3:0] target;
  } ctl_word_t;

  typedef struct packed {
    logic skip;
    logic div_busy;
    logic out_busy;
  } stat_t;

  function automatic ctl_word_t ucode(input logic [3:0] pc);
    ctl_word_t w;
    w = '{op: OP_NOP, cond: CND_JUMP, target: PC_FETCH};
    case (pc)
      PC_FETCH: w = '{op: OP_FETCH, cond: CND_FETCH, target: PC_FETCH};
      PC_START: w = '{op: OP_START, cond: CND_SKIP,  target: PC_EMIT};
      PC_DIV:   w = '{op: OP_NOP,   cond: CND_DIV,   target: PC_SLOPE};
      PC_SLOPE: w = '{op: OP_SLOPE, cond: CND_JUMP,  target: PC_EMIT};
      PC_ERR:   w = '{op: OP_ERR,   cond: CND_SKIP,  target: PC_EMIT};
      PC_MAG:   w = '{op: OP_MAG,   cond: CND_NEXT,  target: PC_FETCH};
      PC_MUL:   w = '{op: OP_MUL,   cond: CND_NEXT,  target: PC_FETCH};
      PC_CLAMP: w = '{op: OP_CLAMP, cond: CND_JUMP,  target: PC_EMIT};
      PC_LIMIT: w = '{op: OP_LIMIT, cond: CND_JUMP,  target: PC_EMIT};
      PC_EMIT:  w = '{op: OP_EMIT,  cond: CND_OUT,   target: PC_FETCH};
      default:  w = '{op: OP_NOP,   cond: CND_JUMP,  target: PC_FETCH};
    endcase
    return w;
  endfunction

  function automatic logic [3:0] entry_pc(input logic [1:0] mode);
    logic [3:0] pc;
    case (mode)
      MODE_START: pc = PC_START;
      MODE_STEP:  pc = PC_ERR;
      MODE_LIMIT: pc = PC_LIMIT;
      default:    pc = PC_EMIT;
    endcase
    return pc;
  endfunction

  function automatic logic [1:0] sign_code(input logic signed [33:0] v);
    logic [1:0] d;
    if (v == '0) begin
      d = DIR_NONE;
    end else if (v[33]) begin
      d = DIR_NEG;
    end else begin
      d = DIR_POS;
    end
    return d;
  endfunction

endpackage

// ----- hw/rtl/distance_speed_ramp_top.sv -----
// Start: 39-step divider and slope, both skipped if no slope is needed; step: error, magnitude,
// multiply, clamp, or error only when skipped; speed limit: limit; all then load the output.
// One transaction is in work at a time; the next can be accepted in the cycle after the result is
// loaded, even while that result waits in the output register.
// Reset is synchronous and active low; it clears the configuration, the movement state and
// the sequencer, and the block accepts a transaction in the first cycle after it.
module distance_speed_ramp_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // enable_request, speed_limit, target_position, current_position
  input  logic [1:0]  in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // speed, ramp_active
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [30:0] cfg_wdata
);

  dsr_pkg::ctl_word_t ctl;
  dsr_pkg::stat_t     stat;
  logic               take;
  logic               accept;

  assign in_tready = take;
  assign accept    = in_tvalid && take;

  dsr_useq u_useq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .mode      (in_tuser),
    .stat      (stat),
    .ctl       (ctl),
    .take      (take)
  );

  dsr_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .accept     (accept),
    .in_data    (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .stat       (stat)
  );

  a_leave_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("sequencer stayed in fetch after a transaction was accepted");

  a_div_idle_at_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !stat.div_busy)
    else $error("divider busy while a new transaction can be accepted");

  a_start_divides: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == dsr_pkg::OP_START) && !stat.skip |=> stat.div_busy)
    else $error("start without skip did not launch the divider");

endmodule

// ----- hw/rtl/dsr_useq.sv -----
// Microcode sequencer: step counter, control store lookup and branch logic.
module dsr_useq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic [1:0]        mode,
  input  dsr_pkg::stat_t    stat,
  output dsr_pkg::ctl_word_t ctl,
  output logic              take
);

  logic [3:0] pc_r;
  logic [3:0] pc_nxt;
  logic [3:0] pc_inc;

  assign ctl    = dsr_pkg::ucode(pc_r);
  assign take   = (ctl.op == dsr_pkg::OP_FETCH);
  assign pc_inc = pc_r + 4'd1;

  always_comb begin
    case (ctl.cond)
      dsr_pkg::CND_NEXT:  pc_nxt = pc_inc;
      dsr_pkg::CND_JUMP:  pc_nxt = ctl.target;
      dsr_pkg::CND_FETCH: pc_nxt = in_tvalid ? dsr_pkg::entry_pc(mode) : pc_r;
      dsr_pkg::CND_SKIP:  pc_nxt = stat.skip ? ctl.target : pc_inc;
      dsr_pkg::CND_DIV:   pc_nxt = stat.div_busy ? pc_r : ctl.target;
      dsr_pkg::CND_OUT:   pc_nxt = stat.out_busy ? pc_r : ctl.target;
      default:            pc_nxt = dsr_pkg::PC_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= dsr_pkg::PC_FETCH;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ----- hw/rtl/dsr_div.sv -----
// Restoring divider that forms (num_hi << 32) / divisor one quotient bit per cycle.
module dsr_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [6:0]                 num_hi,
  input  logic [30:0]                divisor,
  output logic                       busy,
  output logic [dsr_pkg::QUOT_W-1:0] quot
);

  logic [dsr_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [30:0]                   rem_r;
  logic [dsr_pkg::QUOT_W-1:0]    q_r;
  logic [30:0]                   dvs_r;
  logic [31:0]                   rem_sh;
  logic [32:0]                   diff;
  logic                          fit;

  assign rem_sh = {rem_r, q_r[dsr_pkg::QUOT_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b0, dvs_r};
  assign fit    = !diff[32];
  assign busy   = (cnt_r != '0);
  assign quot   = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= dsr_pkg::DIV_CNT_W'(dsr_pkg::DIV_STEPS);
    end else if (busy) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= {num_hi, 32'd0};
      dvs_r <= divisor;
    end else if (busy) begin
      rem_r <= fit ? diff[30:0] : rem_sh[30:0];
      q_r   <= {q_r[dsr_pkg::QUOT_W-2:0], fit};
    end
  end

endmodule

// ----- hw/rtl/dsr_dp.sv -----
// Datapath: configuration, movement state, error, product and clamp, output register.
module dsr_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  dsr_pkg::ctl_word_t ctl,
  input  logic               accept,
  input  logic [79:0]        in_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [30:0]        cfg_wdata,
  input  logic               out_tready,
  output logic               out_tvalid,
  output logic [15:0]        out_tdata,
  output dsr_pkg::stat_t     stat
);

  logic [6:0]         min_r;
  logic [30:0]        rd_r;
  logic               en_r;
  logic [14:0]        lim_r;
  logic signed [31:0] tgt_r;
  logic signed [31:0] cur_r;

  logic               active_r;
  logic [1:0]         dir_r;
  logic signed [32:0] end_r;
  logic [31:0]        slope_r;
  logic [14:0]        cap_r;
  logic [14:0]        last_r;
  logic signed [33:0] err_r;
  logic [30:0]        mag_r;
  logic               far_r;
  logic [62:0]        prod_r;
  logic               oval_r;
  logic [15:0]        odata_r;

  logic [14:0]        minq;
  logic signed [33:0] diff;
  logic [1:0]         dir_new;
  logic signed [32:0] end_pos;
  logic signed [32:0] end_neg;
  logic               act_req;
  logic signed [33:0] err;
  logic [1:0]         err_dir;
  logic [33:0]        mag;
  logic [38:0]        drop;
  logic [14:0]        raw;
  logic [14:0]        last_nxt;
  logic               div_start;
  logic               div_busy;
  logic [dsr_pkg::QUOT_W-1:0] quot;
  logic               out_busy;
  logic               start_skip;
  logic               step_skip;

  assign minq    = {min_r, 8'd0};
  assign diff    = {{2{tgt_r[31]}}, tgt_r} - {{2{cur_r[31]}}, cur_r};
  assign dir_new = dsr_pkg::sign_code(diff);
  assign end_pos = {cur_r[31], cur_r} + {2'b00, rd_r};
  assign end_neg = {cur_r[31], cur_r} - {2'b00, rd_r};
  assign act_req = (lim_r < minq) ? 1'b0 : en_r;
  assign err     = {end_r[32], end_r} - {{2{cur_r[31]}}, cur_r};
  assign err_dir = dsr_pkg::sign_code(err);
  assign mag     = err_r[33] ? 34'(-err_r) : 34'(err_r);
  assign drop    = prod_r[62:24];

  assign start_skip = (dir_new == dsr_pkg::DIR_NONE) || (rd_r == '0);
  assign step_skip  = !active_r || (err_dir != dir_r);
  assign div_start  = (ctl.op == dsr_pkg::OP_START) && !start_skip;
  assign out_busy   = oval_r && !out_tready;

  always_comb begin
    case (ctl.op)
      dsr_pkg::OP_START: stat.skip = start_skip;
      dsr_pkg::OP_ERR:   stat.skip = step_skip;
      default:           stat.skip = 1'b0;
    endcase
    stat.div_busy = div_busy;
    stat.out_busy = out_busy;
  end

  always_comb begin
    if (far_r || (drop >= 39'(dsr_pkg::FULL_SPEED_Q8))) begin
      raw = '0;
    end else begin
      raw = dsr_pkg::FULL_SPEED_Q8 - drop[14:0];
    end
    if (raw > cap_r) begin
      last_nxt = cap_r;
    end else if (raw < minq) begin
      last_nxt = minq;
    end else begin
      last_nxt = raw;
    end
  end

  dsr_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .num_hi  (dsr_pkg::MAX_WHOLE - min_r),
    .divisor (rd_r),
    .busy    (div_busy),
    .quot    (quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= '0;
      rd_r  <= '0;
    end else if (cfg_we) begin
      if (cfg_index == dsr_pkg::CFG_MIN_SPEED) begin
        min_r <= cfg_wdata[6:0];
      end else begin
        rd_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      en_r  <= in_data[0];
      lim_r <= in_data[15:1];
      tgt_r <= in_data[47:16];
      cur_r <= in_data[79:48];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      dir_r    <= dsr_pkg::DIR_NONE;
      end_r    <= '0;
      slope_r  <= '0;
      cap_r    <= '0;
      last_r   <= '0;
    end else begin
      case (ctl.op)
        dsr_pkg::OP_START: begin
          cap_r <= lim_r;
          dir_r <= dir_new;
          if (dir_new == dsr_pkg::DIR_NONE) begin
            active_r <= 1'b0;
            last_r   <= lim_r;
          end else begin
            end_r <= (dir_new == dsr_pkg::DIR_POS) ? end_pos : end_neg;
            if (rd_r == '0) begin
              slope_r  <= '0;
              active_r <= 1'b0;
            end else begin
              active_r <= act_req;
            end
          end
        end
        dsr_pkg::OP_SLOPE: begin
          slope_r <= (quot[38:32] != '0) ? '1 : quot[31:0];
        end
        dsr_pkg::OP_ERR: begin
          if (!active_r) begin
            last_r <= cap_r;
          end else if (err_dir != dir_r) begin
            active_r <= 1'b0;
          end
        end
        dsr_pkg::OP_CLAMP: begin
          last_r <= last_nxt;
        end
        dsr_pkg::OP_LIMIT: begin
          cap_r <= lim_r;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == dsr_pkg::OP_ERR) begin
      err_r <= err;
    end
    if (ctl.op == dsr_pkg::OP_MAG) begin
      mag_r <= mag[30:0];
      far_r <= (mag > {3'b000, rd_r});
    end
    if (ctl.op == dsr_pkg::OP_MUL) begin
      prod_r <= slope_r * mag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oval_r <= 1'b0;
    end else if ((ctl.op == dsr_pkg::OP_EMIT) && !out_busy) begin
      oval_r <= 1'b1;
    end else if (out_tready) begin
      oval_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((ctl.op == dsr_pkg::OP_EMIT) && !out_busy) begin
      odata_r <= {active_r, last_r};
    end
  end

  assign out_tvalid = oval_r;
  assign out_tdata  = odata_r;

endmodule
